// ===== rtl/core/mrc_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the Modbus RTU response checker.
// No dependencies; every other file of the block imports this package.
package mrc_pkg;

	localparam int MAX_READ_REGISTERS_DEF = 9;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] EXC_FLAG = 8'h80;
	localparam logic [7:0] FN_READ  = 8'h03;
	localparam logic [7:0] FN_WRITE = 8'h10;
	localparam logic [7:0] FN_INIT  = 8'h39;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// init echo body is 01 02 03 04
	localparam logic [7:0] INIT_ECHO_0 = 8'h01;
	localparam logic [7:0] INIT_ECHO_1 = 8'h02;
	localparam logic [7:0] INIT_ECHO_2 = 8'h03;
	localparam logic [7:0] INIT_ECHO_3 = 8'h04;

	// frame lengths in bytes
	localparam int LEN_EXC      = 5;
	localparam int LEN_ECHO     = 8;
	localparam int LEN_READ_OVH = 5;

	localparam logic [7:0]  UNIT_RST  = 8'h00;
	localparam logic [7:0]  FUNC_RST  = 8'h03;
	localparam logic [15:0] ADDR_RST  = 16'h0000;
	localparam logic [3:0]  COUNT_RST = 4'd1;

	typedef enum logic [1:0] {
		CFG_UNIT  = 2'd0,
		CFG_FUNC  = 2'd1,
		CFG_ADDR  = 2'd2,
		CFG_COUNT = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_BUSY   = 4'd0,
		ST_OK     = 4'd1,
		ST_UNIT   = 4'd2,
		ST_FUNC   = 4'd3,
		ST_BCOUNT = 4'd4,
		ST_CRC    = 4'd5,
		ST_EXC    = 4'd6,
		ST_CONTENT= 4'd7,
		ST_STRAY  = 4'd8
	} status_t;

	typedef struct packed {
		logic [7:0]  unit;
		logic [7:0]  func;
		logic [15:0] addr;
		logic [3:0]  count;
	} cfg_t;

	// one classified byte as it travels from front to back
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       first_byte;
		logic       unit_ok;
		logic       fn_exc;
		logic       fn_read;
		logic       fn_write;
		logic       fn_init;
		logic       bc_too_big;
		logic       bc_fault;
		logic [3:0] write_bad;  // write echo body mismatch at positions 2..5
		logic [3:0] init_bad;   // init echo body mismatch at positions 2..5
	} item_t;

	function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		int i;
		c = crc ^ {8'h00, b};
		for (i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/mrc_front.sv =====
// Front end: classifies each incoming byte against the configuration.
// Depends on mrc_pkg.
module mrc_front #(
	parameter int MAX_READ_REGISTERS = mrc_pkg::MAX_READ_REGISTERS_DEF
) (
	input  logic [7:0]    rx_byte,
	input  logic          first_byte,
	input  mrc_pkg::cfg_t cfg,
	output mrc_pkg::item_t item
);
	import mrc_pkg::*;

	localparam logic [8:0] BC_MAX = 9'(2 * MAX_READ_REGISTERS);

	logic [3:0] write_bad;
	logic [3:0] init_bad;

	always_comb begin
		write_bad[0] = rx_byte != cfg.addr[15:8];
		write_bad[1] = rx_byte != cfg.addr[7:0];
		write_bad[2] = rx_byte != 8'h00;
		write_bad[3] = rx_byte != {4'h0, cfg.count};
		init_bad[0]  = rx_byte != INIT_ECHO_0;
		init_bad[1]  = rx_byte != INIT_ECHO_1;
		init_bad[2]  = rx_byte != INIT_ECHO_2;
		init_bad[3]  = rx_byte != INIT_ECHO_3;
	end

	always_comb begin
		item.rx_byte    = rx_byte;
		item.first_byte = first_byte;
		item.unit_ok    = rx_byte == cfg.unit;
		item.fn_exc     = rx_byte == (cfg.func | EXC_FLAG);
		item.fn_read    = (rx_byte == FN_READ) && (cfg.func == FN_READ);
		item.fn_write   = (rx_byte == cfg.func) && (rx_byte == FN_WRITE);
		item.fn_init    = (rx_byte == cfg.func) && (rx_byte == FN_INIT);
		item.bc_too_big = {1'b0, rx_byte} > BC_MAX;
		item.bc_fault   = rx_byte[0] | ({1'b0, rx_byte} < {4'h0, cfg.count, 1'b0});
		// the back picks the vector by the frame kind it latched
		item.write_bad  = write_bad;
		item.init_bad   = init_bad;
	end

endmodule

// ===== rtl/core/mrc_queue.sv =====
// Short FIFO of classified bytes between front and back.
// Depends on mrc_pkg.
module mrc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mrc_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output mrc_pkg::item_t head_item
);
	import mrc_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return r;
	endfunction

	assign full       = count_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/mrc_back.sv =====
// Back end: frame parser state, CRC accumulation and the registered result beat.
// Depends on mrc_pkg.
module mrc_back #(
	parameter int MAX_READ_REGISTERS = mrc_pkg::MAX_READ_REGISTERS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mrc_pkg::cfg_t  cfg,
	input  logic           head_valid,
	input  mrc_pkg::item_t head_item,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [3:0]     status,
	output logic           frame_done,
	output logic [7:0]     data_byte,
	output logic           data_valid,
	output logic [7:0]     exception_code
);
	import mrc_pkg::*;

	localparam int LEN_W = $clog2(2 * MAX_READ_REGISTERS + 7);
	localparam int CMP_W = (LEN_W > 5) ? LEN_W : 5;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_FUNC = 3'b010,
		PH_BODY = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		K_READ  = 2'd0,
		K_WRITE = 2'd1,
		K_INIT  = 2'd2,
		K_EXC   = 2'd3
	} kind_t;

	phase_t           phase_q, n_phase;
	kind_t            kind_q, n_kind;
	logic [15:0]      crc_q, n_crc;
	logic [LEN_W-1:0] pos_q, n_pos;
	logic [LEN_W-1:0] len_q, n_len;
	logic             cerr_q, n_cerr;
	logic             isexc_q, n_isexc;
	logic             cnterr_q, n_cnterr;
	logic [7:0]       code_q, n_code;
	logic [7:0]       low_q, n_low;

	status_t          r_status;
	logic             r_done;
	logic [7:0]       r_dbyte;
	logic             r_dvalid;
	logic [7:0]       r_exc;

	logic             out_valid_q;
	status_t          status_q;
	logic             done_q;
	logic [7:0]       dbyte_q;
	logic             dvalid_q;
	logic [7:0]       exc_q;

	logic             can_load;
	logic [7:0]       b;
	logic [LEN_W:0]   p_plus2;
	logic [LEN_W-1:0] p_minus2;
	logic [LEN_W-1:0] p_minus3;
	logic [15:0]      rx_crc;

	assign can_load = !out_valid_q || !out_stall;
	assign pop      = head_valid && can_load;

	assign b        = head_item.rx_byte;
	assign p_plus2  = {1'b0, pos_q} + (LEN_W+1)'(2);
	assign p_minus2 = pos_q - LEN_W'(2);
	assign p_minus3 = pos_q - LEN_W'(3);
	assign rx_crc   = {b, low_q};

	always_comb begin
		n_phase  = phase_q;
		n_kind   = kind_q;
		n_crc    = crc_q;
		n_pos    = pos_q;
		n_len    = len_q;
		n_cerr   = cerr_q;
		n_isexc  = isexc_q;
		n_cnterr = cnterr_q;
		n_code   = code_q;
		n_low    = low_q;
		r_status = ST_BUSY;
		r_done   = 1'b0;
		r_dbyte  = 8'h00;
		r_dvalid = 1'b0;
		r_exc    = 8'h00;

		if (head_item.first_byte) begin
			n_crc    = crc16_feed(CRC_INIT, b);
			n_pos    = '0;
			n_len    = '0;
			n_cerr   = 1'b0;
			n_isexc  = 1'b0;
			n_cnterr = 1'b0;
			n_code   = 8'h00;
			n_low    = 8'h00;
			n_kind   = K_READ;
			if (!head_item.unit_ok) begin
				r_status = ST_UNIT;
				r_done   = 1'b1;
				n_phase  = PH_IDLE;
			end else begin
				n_phase = PH_FUNC;
				n_pos   = LEN_W'(1);
			end
		end else begin
			unique case (phase_q)
				PH_FUNC: begin
					n_crc = crc16_feed(crc_q, b);
					if (head_item.fn_exc) begin
						n_kind  = K_EXC;
						n_isexc = 1'b1;
						n_len   = LEN_W'(LEN_EXC);
					end else if (head_item.fn_read) begin
						n_kind = K_READ;
						n_len  = '0;
					end else if (head_item.fn_write) begin
						n_kind = K_WRITE;
						n_len  = LEN_W'(LEN_ECHO);
					end else if (head_item.fn_init) begin
						n_kind = K_INIT;
						n_len  = LEN_W'(LEN_ECHO);
					end else begin
						r_status = ST_FUNC;
						r_done   = 1'b1;
						n_phase  = PH_IDLE;
					end
					if (!r_done) begin
						n_phase = PH_BODY;
						n_pos   = LEN_W'(2);
					end
				end
				PH_BODY: begin
					if (kind_q == K_READ && pos_q == LEN_W'(2)) begin
						// byte count of a read reply
						n_crc = crc16_feed(crc_q, b);
						if (head_item.bc_too_big) begin
							r_status = ST_BCOUNT;
							r_done   = 1'b1;
							n_phase  = PH_IDLE;
						end else begin
							if (head_item.bc_fault) begin
								n_cnterr = 1'b1;
							end
							n_len = LEN_W'(9'(LEN_READ_OVH) + {1'b0, b});
						end
					end else if (p_plus2 < {1'b0, len_q}) begin
						n_crc = crc16_feed(crc_q, b);
						case (kind_q)
							K_READ: begin
								if (CMP_W'(p_minus3) < CMP_W'({cfg.count, 1'b0})) begin
									r_dbyte  = b;
									r_dvalid = 1'b1;
								end
							end
							K_EXC: begin
								n_code = b;
							end
							default: begin
								if (kind_q == K_WRITE) begin
									if (head_item.write_bad[p_minus2[1:0]]) begin
										n_cerr = 1'b1;
									end
								end else if (head_item.init_bad[p_minus2[1:0]]) begin
									n_cerr = 1'b1;
								end
							end
						endcase
					end else if (p_plus2 == {1'b0, len_q}) begin
						n_low = b;
					end else begin
						r_done  = 1'b1;
						n_phase = PH_IDLE;
						if (rx_crc != crc_q) begin
							r_status = ST_CRC;
						end else if (isexc_q) begin
							r_status = ST_EXC;
							r_exc    = code_q;
						end else if (cnterr_q) begin
							r_status = ST_BCOUNT;
						end else if (cerr_q) begin
							r_status = ST_CONTENT;
						end else begin
							r_status = ST_OK;
						end
					end
					if (!r_done) begin
						n_pos = pos_q + LEN_W'(1);
					end
				end
				default: begin
					r_status = ST_STRAY;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			kind_q   <= K_READ;
			crc_q    <= CRC_INIT;
			pos_q    <= '0;
			len_q    <= '0;
			cerr_q   <= 1'b0;
			isexc_q  <= 1'b0;
			cnterr_q <= 1'b0;
			code_q   <= 8'h00;
			low_q    <= 8'h00;
		end else if (pop) begin
			phase_q  <= n_phase;
			kind_q   <= n_kind;
			crc_q    <= n_crc;
			pos_q    <= n_pos;
			len_q    <= n_len;
			cerr_q   <= n_cerr;
			isexc_q  <= n_isexc;
			cnterr_q <= n_cnterr;
			code_q   <= n_code;
			low_q    <= n_low;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= r_status;
			done_q   <= r_done;
			dbyte_q  <= r_dbyte;
			dvalid_q <= r_dvalid;
			exc_q    <= r_exc;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign frame_done     = done_q;
	assign data_byte      = dbyte_q;
	assign data_valid     = dvalid_q;
	assign exception_code = exc_q;

endmodule

// ===== rtl/core/modbus_rtu_response_checker.sv =====
// Modbus RTU response checker, top level: configuration registers, front, queue and back.
// Depends on mrc_pkg, mrc_front, mrc_queue and mrc_back.
//
// Feed the response one byte per input beat, first_byte marking the unit id, and take one
// status beat per byte. While out_stall is low the block sustains one byte per clock: the
// front classifies a byte against the configuration as it is accepted, a two-entry queue
// holds it, and the back updates the parser state (position, length, running CRC-16) and
// loads the result register. The queue is written when a byte is accepted, and the result
// register is loaded when the back pops it, which an output stall can delay.
// The queue absorbs output stalls; in_stall rises only when it is full. Frame lengths: an
// exception reply is 5 bytes, a read reply 5 plus its byte count, a write or init echo 8.
// Register data of a read is streamed with data_valid while the frame is still being
// checked, so treat it as tentative until the frame ends with status ok. Configuration
// writes (cfg_ready is always high) must only happen while no byte is in flight.
module modbus_rtu_response_checker #(
	parameter int MAX_READ_REGISTERS = mrc_pkg::MAX_READ_REGISTERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        first_byte,
	// status output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic        frame_done,
	output logic [7:0]  data_byte,
	output logic        data_valid,
	output logic [7:0]  exception_code,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import mrc_pkg::*;

	cfg_t  cfg_q;
	item_t front_item;
	item_t head_item;
	logic  queue_full;
	logic  push;
	logic  head_valid;
	logic  pop;

	// configuration registers; writes truncate to the register width
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unit  <= UNIT_RST;
			cfg_q.func  <= FUNC_RST;
			cfg_q.addr  <= ADDR_RST;
			cfg_q.count <= COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_UNIT:  cfg_q.unit  <= cfg_data[7:0];
				CFG_FUNC:  cfg_q.func  <= cfg_data[7:0];
				CFG_ADDR:  cfg_q.addr  <= cfg_data;
				CFG_COUNT: cfg_q.count <= cfg_data[3:0];
				default:   cfg_q       <= cfg_q;
			endcase
		end
	end

	// front: classify the byte as it arrives
	mrc_front #(
		.MAX_READ_REGISTERS(MAX_READ_REGISTERS)
	) u_front (
		.rx_byte   (rx_byte),
		.first_byte(first_byte),
		.cfg       (cfg_q),
		.item      (front_item)
	);

	assign in_stall = queue_full;
	assign push     = in_valid && !in_stall;

	mrc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (queue_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_item (head_item)
	);

	// back: parser state and result register
	mrc_back #(
		.MAX_READ_REGISTERS(MAX_READ_REGISTERS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.frame_done    (frame_done),
		.data_byte     (data_byte),
		.data_valid    (data_valid),
		.exception_code(exception_code)
	);

	// a finished or failed frame never reports busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> status != ST_BUSY)
		else $error("frame_done with busy status");

	// register data only appears inside an unfinished frame
	a_data_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && data_valid |-> status == ST_BUSY && !frame_done)
		else $error("data_valid outside a running frame");

	// the exception code is only reported with an exception status
	a_exc_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && exception_code != 8'h00 |-> status == ST_EXC)
		else $error("exception code without exception status");

	// a byte accepted into an empty block with a free output passes the queue and becomes a result beat
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !head_valid && (!out_valid || !out_stall) |=> ##1 out_valid)
		else $error("accepted byte did not reach the output");

endmodule
